FILE: hw/rtl/vdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and defaults for the vertex dedup table.
// No dependencies; used by the table top level, the hash pipeline and the checker.
package vdt_pkg;

    // Default table depth and width of the per-entry mesh tag
    localparam int VDT_TABLE_ENTRIES = 1024;
    localparam int VDT_EPOCH_W       = 8;
    localparam int VDT_WORD_W        = 32;

    // Folded position key: word 0 is x, word 1 is y, word 2 is z
    typedef logic [2:0][VDT_WORD_W-1:0] t_vdt_key;

    // Input beat
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic        start_mesh;
    } t_vdt_in;

    // Result beat
    typedef struct packed {
        logic [9:0]  merged_index;
        logic        is_new;
        logic        overflow;
        logic [15:0] input_number;
        logic [10:0] unique_count;
    } t_vdt_out;

endpackage

FILE: hw/rtl/vertex_dedup_table.sv
`timescale 1ns / 1ps
// Vertex dedup table: merges repeated vertex positions within a mesh.
// Input channel i_in_valid/o_in_stall carries one position per beat (x, y, z
// raw float words plus start_mesh); output channel o_out_valid/i_out_stall
// returns one result beat per input beat, in order.
// Each position is hashed (four pipeline stages) and looked up by linear
// probing in one single-port table RAM, one probe per cycle. The result is
// registered after the hash and the probes, and the next input beat is taken
// only after that result has gone to the output register: one vertex at a time.
// A full table searched for a new position probes every entry.
// Table entries carry a mesh tag; start_mesh bumps the tag instead of
// clearing. After reset, and on every 256th start_mesh when the tag wraps,
// a clearing pass writes all TABLE_ENTRIES entries, one per cycle, while
// the input is stalled.
// A stalled result stays in the output register; the block still finishes
// the next vertex up to its result and waits there.
// Depends on vdt_pkg, vdt_ram and vdt_hash.
module vertex_dedup_table import vdt_pkg::*; #(
    parameter int TABLE_ENTRIES = VDT_TABLE_ENTRIES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_vdt_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_vdt_out o_out
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = AW;
    localparam int KW = 3 * VDT_WORD_W;
    localparam int EW = VDT_EPOCH_W;
    localparam int RW = 1 + EW + IW + KW;

    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(TABLE_ENTRIES - 1);
    localparam logic [EW-1:0] LAST_EPOCH = '1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    function automatic logic [31:0] fold_zero(input logic [31:0] w);
        return (w == 32'h8000_0000) ? 32'h0000_0000 : w;
    endfunction

    logic [2:0]    r_state;
    t_vdt_key      r_key;
    logic [EW-1:0] r_epoch;
    logic [CW-1:0] r_next;
    logic [15:0]   r_cnt;
    logic [15:0]   r_num;
    logic [AW-1:0] r_clr_addr;
    logic          r_item;
    logic [AW-1:0] r_slot;
    logic [CW-1:0] r_probes;
    logic [IW-1:0] r_res_idx;
    logic          r_res_new;
    logic          r_res_ovf;
    logic          r_out_valid;
    t_vdt_out      r_out;

    t_vdt_key      w_key_in, w_hash_key;
    logic          w_accept, w_wrap, w_out_free, w_hash_go, w_hash_valid;
    logic [AW-1:0] w_hash_slot, w_next_slot;
    logic [CW-1:0] w_probes_inc;
    logic          w_live, w_hit, w_last_probe, w_room;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_addr;
    logic [RW-1:0] w_ram_wdata, w_rdata;
    logic [KW-1:0] w_rd_key;
    logic [IW-1:0] w_rd_index;
    logic [EW-1:0] w_rd_epoch;
    logic          w_rd_valid;

    // Input side: fold minus zero, take a beat only when idle
    assign w_key_in[0] = fold_zero(i_in.pos_x);
    assign w_key_in[1] = fold_zero(i_in.pos_y);
    assign w_key_in[2] = fold_zero(i_in.pos_z);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_wrap      = i_in.start_mesh && (r_epoch == LAST_EPOCH);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Start hashing at accept, or after a tag-wrap clearing pass
    assign w_hash_go  = (w_accept && !w_wrap) ||
                        ((r_state == ST_CLEAR) && (r_clr_addr == LAST_SLOT) && r_item);
    assign w_hash_key = (r_state == ST_IDLE) ? w_key_in : r_key;

    vdt_hash #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_hash (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (w_hash_go),
        .i_key  (w_hash_key),
        .o_valid(w_hash_valid),
        .o_slot (w_hash_slot)
    );

    // Entry layout: valid, mesh tag, dense index, key
    assign w_rd_key   = w_rdata[KW-1:0];
    assign w_rd_index = w_rdata[KW +: IW];
    assign w_rd_epoch = w_rdata[KW + IW +: EW];
    assign w_rd_valid = w_rdata[RW-1];

    // Probe decode for the entry that r_slot addressed
    assign w_live       = w_rd_valid && (w_rd_epoch == r_epoch);
    assign w_hit        = w_live && (w_rd_key == r_key);
    assign w_room       = (r_next != FULL_COUNT);
    assign w_next_slot  = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign w_probes_inc = r_probes + 1'b1;
    assign w_last_probe = (w_probes_inc == FULL_COUNT);

    // RAM port: clear sweep, first probe, next probe or append
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_addr  = r_slot;
        w_ram_wdata = {1'b1, r_epoch, IW'(r_next), r_key};
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_clr_addr;
                w_ram_wdata = '0;
            end
            ST_HASH: begin
                w_ram_addr = w_hash_slot;
            end
            ST_PROBE: begin
                if (!w_live && w_room) begin
                    w_ram_we   = 1'b1;
                    w_ram_addr = r_slot;
                end else begin
                    w_ram_addr = w_next_slot;
                end
            end
            default: begin
                w_ram_addr = r_slot;
            end
        endcase
    end

    vdt_ram #(
        .WIDTH(RW),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_addr (w_ram_addr),
        .i_wdata(w_ram_wdata),
        .o_rdata(w_rdata)
    );

    // Control: sequencer, counters, mesh tag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_item      <= 1'b0;
            r_epoch     <= '0;
            r_next      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in.start_mesh) begin
                            r_next  <= '0;
                            r_cnt   <= 16'd1;
                            r_epoch <= r_epoch + 1'b1;
                        end else begin
                            r_cnt <= r_cnt + 16'd1;
                        end
                        r_item     <= w_wrap;
                        r_clr_addr <= '0;
                        r_state    <= w_wrap ? ST_CLEAR : ST_HASH;
                    end
                end
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_SLOT) begin
                        r_state <= r_item ? ST_HASH : ST_IDLE;
                    end
                end
                ST_HASH: begin
                    if (w_hash_valid) begin
                        r_state <= ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    if (!w_live) begin
                        if (w_room) begin
                            r_next <= r_next + 1'b1;
                        end
                        r_state <= ST_DONE;
                    end else if (w_hit || w_last_probe) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: key, input number, probe position and lookup outcome
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= w_key_in;
            r_num <= i_in.start_mesh ? 16'd0 : r_cnt;
        end
        if ((r_state == ST_HASH) && w_hash_valid) begin
            r_slot   <= w_hash_slot;
            r_probes <= '0;
        end
        if (r_state == ST_PROBE) begin
            r_slot    <= w_next_slot;
            r_probes  <= w_probes_inc;
            r_res_idx <= w_rd_index;
            r_res_new <= 1'b0;
            r_res_ovf <= 1'b0;
            if (!w_live) begin
                if (w_room) begin
                    r_res_idx <= IW'(r_next);
                    r_res_new <= 1'b1;
                end else begin
                    r_res_idx <= '0;
                    r_res_ovf <= 1'b1;
                end
            end else if (!w_hit) begin
                r_res_idx <= '0;
                r_res_ovf <= w_last_probe;
            end
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out.merged_index <= 10'(r_res_idx);
            r_out.is_new       <= r_res_new;
            r_out.overflow     <= r_res_ovf;
            r_out.input_number <= r_num;
            r_out.unique_count <= 11'(r_next);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hw/rtl/vdt_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies; instantiated by the vertex dedup table.
module vdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/vdt_hash.sv
`timescale 1ns / 1ps
// Hash pipeline: mixes the folded key and reduces it modulo the table depth.
// Depends on vdt_pkg for the key type.
module vdt_hash import vdt_pkg::*; #(
    parameter int TABLE_ENTRIES = VDT_TABLE_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_go,
    input  t_vdt_key                         i_key,
    output logic                             o_valid,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_slot
);

    localparam int          AW         = $clog2(TABLE_ENTRIES);
    localparam logic [31:0] MIX_X      = 32'h9E37_79B1;
    localparam logic [31:0] MIX_Y      = 32'h85EB_CA77;
    localparam logic [31:0] MIX_Z      = 32'hC2B2_AE3D;
    localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / 64'(TABLE_ENTRIES);
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
    localparam logic [31:0] MODULUS    = 32'(TABLE_ENTRIES);

    logic          r_v1, r_v2, r_v3, r_v4;
    logic [31:0]   r_mx, r_my, r_mz;
    logic [31:0]   r_h, r_h2, r_q, r_qn;
    logic [AW-1:0] r_slot;
    logic [31:0]   w_mix, w_h, w_qn, w_rem, w_red;
    logic [63:0]   w_prod;

    // Stage 2: fold the products and estimate the quotient by reciprocal
    assign w_mix  = r_mx ^ r_my ^ r_mz;
    assign w_h    = w_mix ^ (w_mix >> 16);
    assign w_prod = 64'(w_h) * 64'(RECIP);
    // Stage 3: quotient times depth, never above the hash itself
    assign w_qn   = r_q * MODULUS;
    // Stage 4: remainder is below twice the depth, so one correction
    assign w_rem  = r_h2 - r_qn;
    assign w_red  = (w_rem >= MODULUS) ? (w_rem - MODULUS) : w_rem;

    // Advance the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_go;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        r_mx   <= i_key[0] * MIX_X;
        r_my   <= i_key[1] * MIX_Y;
        r_mz   <= i_key[2] * MIX_Z;
        r_h    <= w_h;
        r_q    <= w_prod[63:32];
        r_h2   <= r_h;
        r_qn   <= w_qn;
        r_slot <= w_red[AW-1:0];
    end

    assign o_valid = r_v4;
    assign o_slot  = r_slot;

endmodule

FILE: hw/rtl/vdt_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the vertex dedup table, bound to its top level.
// Depends on vdt_pkg for the beat types.
module vdt_chk import vdt_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_vdt_out o_out
);

    // Busy right after taking a beat: one vertex at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a vertex is in flight");

    // Hold a stalled result beat
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result beat changed or dropped");

    // A result only appears at the end of a busy period
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a vertex in flight");

    // Overflow never carries an index or a new flag
    a_overflow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.overflow) |-> (!o_out.is_new && (o_out.merged_index == 10'd0)))
        else $error("overflow result with index or new flag");

endmodule

bind vertex_dedup_table vdt_chk u_vdt_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);
